// ===== hw/rtl/tws_pkg.sv =====
// ---------------------------------------------------------------------------
// Timing window statistics package
// Shared types and constants for the timing window statistics block.
// ---------------------------------------------------------------------------
package tws_pkg;

  localparam logic [31:0] MS_Q16_SCALE = 32'd65536000;
  localparam logic [31:0] SAT32        = 32'hFFFF_FFFF;
  localparam logic [31:0] FREQ_RESET   = 32'd1000000000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONV,
    ST_DIV1,
    ST_SCALE,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DIV2,
    ST_OUT
  } tws_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic conv_start;
    logic div_start;
    logic div_step;
    logic scale;
    logic sample_wr;
    logic scan_start;
    logic scan_step;
    logic scan_last;
    logic mean_start;
    logic out_load;
  } tws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic scan_done;
  } tws_status_t;

endpackage

// ===== hw/rtl/tws_if.sv =====
// ---------------------------------------------------------------------------
// Valid/ready channel
// Generic payload channel with a source and a sink side.
// ---------------------------------------------------------------------------
interface tws_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tws_ctrl.sv =====
// ---------------------------------------------------------------------------
// Timing window statistics controller
// Sequences conversion, ring update, window scan and mean division.
// ---------------------------------------------------------------------------
module tws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_busy_i,
  input  tws_pkg::tws_status_t status_i,
  output tws_pkg::tws_cmd_t   cmd_o
);
  import tws_pkg::*;

  tws_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_start = 1'b1;
        cmd_o.div_start  = 1'b1;
        state_d          = ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.sample_wr  = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: begin
        cmd_o.scan_last  = 1'b1;
        cmd_o.mean_start = 1'b1;
        state_d          = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/tws_datapath.sv =====
// ---------------------------------------------------------------------------
// Timing window statistics datapath
// Sample store, ring pointers, shared restoring divider and scan unit.
// ---------------------------------------------------------------------------
module tws_datapath #(
  parameter int PROFILE_SLOTS = 16,
  parameter int WINDOW_DEPTH  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tws_pkg::tws_cmd_t    cmd_i,
  output tws_pkg::tws_status_t status_o,
  input  logic [31:0]          freq_i,
  input  logic [3:0]           profile_index_i,
  input  logic [63:0]          start_ticks_i,
  input  logic [63:0]          end_ticks_i,
  input  logic                 data_present_i,
  input  logic                 was_started_i,
  output logic [3:0]           slot_o,
  output logic [31:0]          sample_ms_o,
  output logic [31:0]          mean_ms_o,
  output logic [31:0]          peak_ms_o,
  output logic [6:0]           used_samples_o,
  output logic                 show_o
);
  import tws_pkg::*;

  localparam int SW        = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
  localparam int PW        = $clog2(WINDOW_DEPTH);
  localparam int AW        = SW + PW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int CW        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW      = 32 + CW;
  localparam int NW        = 64;                // divider dividend width
  localparam int DCW       = $clog2(NW + 1);

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rd_q;

  // Input capture.
  logic [SW-1:0] slot_q;
  logic [63:0]   delta_q;
  logic          valid_q;
  logic          show_q;
  logic [31:0]   freq_q;

  // The slot index has only 16 values, so its reduction is a constant table.
  logic [SW-1:0] slot_red;
  always_comb begin
    slot_red = '0;
    for (int k = 0; k < 16; k++) begin
      if (profile_index_i == 4'(k)) begin
        slot_red = SW'(k % PROFILE_SLOTS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q  <= slot_red;
      delta_q <= end_ticks_i - start_ticks_i;
      valid_q <= data_present_i && (end_ticks_i > start_ticks_i);
      show_q  <= was_started_i;
      freq_q  <= freq_i;
    end
  end

  // Ring pointers, reset cleared.
  logic [PW-1:0] ptr_q [PROFILE_SLOTS];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROFILE_SLOTS; i++) ptr_q[i] <= '0;
    end else if (cmd_i.sample_wr) begin
      ptr_q[slot_q] <= PW'(32'(ptr_q[slot_q]) + 1 == WINDOW_DEPTH ? 0 :
                           32'(ptr_q[slot_q]) + 1);
    end
  end

  // Shared restoring divider: one quotient bit a cycle.
  logic [NW-1:0]  dv_num_q, dv_quo_q;
  logic [32:0]    dv_rem_q;
  logic [31:0]    dv_den_q;
  logic [DCW-1:0] dv_cnt_q;
  logic [NW-1:0]  div_num;
  logic [31:0]    div_den;
  logic [33:0]    dv_trial;

  assign dv_trial = {dv_rem_q, dv_num_q[NW-1]} - {2'b00, dv_den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start || cmd_i.mean_start) begin
      dv_num_q <= div_num;
      dv_den_q <= div_den;
      dv_rem_q <= '0;
      dv_quo_q <= '0;
      dv_cnt_q <= DCW'(NW);
    end else if (cmd_i.div_step && dv_cnt_q != '0) begin
      dv_num_q <= dv_num_q << 1;
      dv_cnt_q <= dv_cnt_q - 1'b1;
      if (!dv_trial[33]) begin
        dv_rem_q <= dv_trial[32:0];
        dv_quo_q <= {dv_quo_q[NW-2:0], 1'b1};
      end else begin
        dv_rem_q <= {dv_rem_q[31:0], dv_num_q[NW-1]};
        dv_quo_q <= {dv_quo_q[NW-2:0], 1'b0};
      end
    end
  end
  assign status_o.div_done = (dv_cnt_q == DCW'(1));

  // Scan accumulators.
  logic [SUMW-1:0] sum_q;
  logic [CW-1:0]   cnt_q;
  logic [31:0]     peak_q;
  logic [PW:0]     scan_q;
  logic            scan_rd_q;

  // Delta split: q = delta / f done with the same divider. The fractional
  // part r * scale / f < scale, so total = q * scale + (r*scale)/f. Since
  // q * scale < 2^32 is needed, q is checked against that bound, and
  // rather than dividing delta * scale directly, (delta*scale)/f is
  // computed as (q*scale) + floor(r*scale/f) with a 64-bit dividend r*scale.
  logic [31:0] q_lo_q;
  logic        sat_q;
  logic        phase2_q;
  logic [63:0] rs_q;

  always_comb begin
    div_num = cmd_i.mean_start ? NW'(sum_q) : delta_q;
    div_den = cmd_i.mean_start ? 32'(cnt_q) : freq_q;
    if (cmd_i.scale) begin
      div_num = rs_q;
    end
  end

  // Sample assembly.
  logic [31:0] sample_q;
  logic [63:0] qs_prod;
  assign qs_prod = {32'd0, q_lo_q} * {32'd0, MS_Q16_SCALE};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      // First division done: quotient and remainder in the divider.
      sat_q  <= (dv_quo_q > 64'(SAT32 / MS_Q16_SCALE));
      q_lo_q <= dv_quo_q[31:0];
      rs_q   <= 64'(dv_rem_q[31:0]) * 64'(MS_Q16_SCALE);
    end
  end

  // The second division (r*scale/f) runs in a separate divider below. It
  // starts at the scale step; the scan waits until it is done.
  logic [63:0]    f_num_q, f_quo_q;
  logic [32:0]    f_rem_q;
  logic [DCW-1:0] f_cnt_q;
  logic [33:0]    f_trial;
  logic           f_busy_q;
  assign f_trial = {f_rem_q, f_num_q[63]} - {2'b00, freq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_busy_q <= 1'b0;
      f_cnt_q  <= '0;
    end else if (cmd_i.scale) begin
      f_busy_q <= 1'b1;
      f_cnt_q  <= DCW'(NW);
    end else if (f_busy_q) begin
      f_cnt_q  <= f_cnt_q - 1'b1;
      if (f_cnt_q == DCW'(1)) f_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      f_num_q <= 64'(dv_rem_q[31:0]) * 64'(MS_Q16_SCALE);
      f_rem_q <= '0;
      f_quo_q <= '0;
    end else if (f_busy_q) begin
      f_num_q <= f_num_q << 1;
      if (!f_trial[33]) begin
        f_rem_q <= f_trial[32:0];
        f_quo_q <= {f_quo_q[62:0], 1'b1};
      end else begin
        f_rem_q <= {f_rem_q[31:0], f_num_q[63]};
        f_quo_q <= {f_quo_q[62:0], 1'b0};
      end
    end
  end

  logic [64:0] total;
  logic [31:0] sample_c;
  assign total = 65'(qs_prod) + 65'(f_quo_q);
  always_comb begin
    if (!valid_q) sample_c = '0;
    else if (freq_q == '0 || sat_q || total > 65'(SAT32)) sample_c = SAT32;
    else sample_c = total[31:0];
  end

  // Memory: write/clear port and registered read port.
  logic [AW-1:0] clr_q;
  logic          clr_done_q;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clear_wr && !clr_done_q) begin
      clr_q <= clr_q + 1'b1;
      if (32'(clr_q) == MEM_DEPTH - 1) clr_done_q <= 1'b1;
    end
  end
  assign status_o.clear_done = clr_done_q;

  assign wr_en   = cmd_i.clear_wr || (cmd_i.scan_step && !f_busy_q && !phase2_q);
  assign wr_addr = cmd_i.clear_wr ? clr_q : {slot_q, ptr_q[slot_q]};
  assign wr_data = cmd_i.clear_wr ? '0 : sample_c;
  assign rd_addr = {slot_q, scan_q[PW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // Scan: wait for the fraction divider, write the sample, then walk.
  logic scan_go;
  assign scan_go = cmd_i.scan_step && phase2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_start) begin
      phase2_q <= 1'b0;
    end else if (cmd_i.scan_step && !f_busy_q && !phase2_q) begin
      phase2_q  <= 1'b1;
      sample_q  <= sample_c;
      scan_q    <= '0;
      scan_rd_q <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
      peak_q    <= '0;
    end else if (scan_go) begin
      if (!scan_q[PW]) scan_q <= scan_q + 1'b1;
      scan_rd_q <= !scan_q[PW];
      if (scan_rd_q && rd_q != '0) begin
        sum_q <= sum_q + SUMW'(rd_q);
        cnt_q <= cnt_q + 1'b1;
        if (rd_q > peak_q) peak_q <= rd_q;
      end
    end
  end
  assign status_o.scan_done = phase2_q && scan_q[PW] && !scan_rd_q;

  // Output stage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_o         <= 4'(slot_q);
      sample_ms_o    <= sample_q;
      mean_ms_o      <= (cnt_q == '0) ? '0 : dv_quo_q[31:0];
      peak_ms_o      <= peak_q;
      used_samples_o <= 7'(cnt_q);
      show_o         <= show_q;
    end
  end

endmodule

// ===== hw/rtl/timing_window_statistics.sv =====
// ---------------------------------------------------------------------------
// Timing window statistics
// Per-slot sliding window of millisecond samples with peak and mean.
// ---------------------------------------------------------------------------
// Usage: each input word names a profile slot with a start and end
// timestamp. The block turns the delta into a Q16.16 millisecond sample,
// writes it over the oldest entry of the slot's ring, and returns one word
// with the sample, peak, floor mean and count of nonzero entries.
// The cfg channel must write tick_frequency only while the block is
// idle; the block itself does not enforce this. An item is worked
// through a 64-step division of the delta, a 64-step division of the
// remainder, a walk over the ring through the single read port of the
// sample memory, 64 entries with the default window, and a 64-step mean
// division. One item is worked on at a time. After reset a clearing
// pass zeroes the sample memory, one entry a cycle, all 1024 entries with
// the default sizes; no input word is taken meanwhile. The result sits
// in an output register; a new input word is accepted while it waits,
// and the block holds the next result until the waiting one is taken.
// ---------------------------------------------------------------------------
module timing_window_statistics #(
  parameter int PROFILE_SLOTS = 16,
  parameter int WINDOW_DEPTH  = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  tws_if.sink   cfg,
  tws_if.sink   in_ch,
  tws_if.source out_ch
);
  import tws_pkg::*;

  logic [31:0] freq_q;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RESET;
    end else if (cfg.valid) begin
      freq_q <= cfg.data;
    end
  end

  tws_cmd_t    cmd;
  tws_status_t status;
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid_q;

  tws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_busy_i (out_valid_q && !out_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tws_datapath #(
    .PROFILE_SLOTS (PROFILE_SLOTS),
    .WINDOW_DEPTH  (WINDOW_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .freq_i          (freq_q),
    .profile_index_i (in_ch.data.profile_index),
    .start_ticks_i   (in_ch.data.start_ticks),
    .end_ticks_i     (in_ch.data.end_ticks),
    .data_present_i  (in_ch.data.data_present),
    .was_started_i   (in_ch.data.was_started),
    .slot_o          (out_ch.data.slot),
    .sample_ms_o     (out_ch.data.sample_ms),
    .mean_ms_o       (out_ch.data.mean_ms),
    .peak_ms_o       (out_ch.data.peak_ms),
    .used_samples_o  (out_ch.data.used_samples),
    .show_o          (out_ch.data.show)
  );

endmodule

// ===== hw/rtl/tws_checker.sv =====
// ---------------------------------------------------------------------------
// Timing window statistics checker
// Port-level properties of the block, bound to the top level.
// ---------------------------------------------------------------------------
module tws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  used_samples_i,
  input logic [31:0] mean_ms_i,
  input logic [31:0] peak_ms_i
);
  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mean_ms_i))
    else $error("stalled result changed");

  // An accepted input is not followed by another acceptance next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted twice in a row");

  // An empty window reports zero statistics.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && used_samples_i == 7'd0 |-> mean_ms_i == 32'd0 && peak_ms_i == 32'd0)
    else $error("empty window with nonzero statistics");

  // The mean never exceeds the peak.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> mean_ms_i <= peak_ms_i)
    else $error("mean above peak");
endmodule

bind timing_window_statistics tws_checker u_tws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .used_samples_i (out_ch.data.used_samples),
  .mean_ms_i      (out_ch.data.mean_ms),
  .peak_ms_i      (out_ch.data.peak_ms)
);
